FILE: src/sdcbp_pkg.sv
// ----------------------------------------------------------------------------
// SDES chunk byte parser package
// Shared types and constants for the byte-wise source description parser.
// ----------------------------------------------------------------------------
package sdcbp_pkg;

  typedef enum logic [1:0] {
    PH_SSRC = 2'd0,
    PH_TYPE = 2'd1,
    PH_LEN  = 2'd2,
    PH_VAL  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_CONT    = 2'd0,
    ST_OK      = 2'd1,
    ST_NOCNAME = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  localparam logic [7:0] SdesTypeCname = 8'd1;
  localparam logic [15:0] ByteTotalMax = 16'hFFFF;
  localparam logic [1:0] SsrcLastByte = 2'd3;
  localparam logic [7:0] ItemsCfgReset = 8'd1;

  localparam int unsigned OutDataW = 96;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] chunk_bytes;
    logic [7:0]  value_index;
    logic [7:0]  value_byte;
    logic [7:0]  item_length;
    logic [7:0]  item_type;
    logic [7:0]  item_index;
    logic [31:0] ssrc;
  } result_t;

endpackage

FILE: src/sdes_chunk_byte_parser_top.sv
// ----------------------------------------------------------------------------
// SDES chunk byte parser
// Parses a source description chunk one byte per request and emits one
// result per byte with its role, the SSRC and the current item fields.
// An accepted byte's result is registered and appears on the output in the next cycle.
// Throughput is one byte per cycle while the output is not stalled, set by the single output register.
// Reset returns the parser to the SSRC phase and sets the item count to one.
// ----------------------------------------------------------------------------
module sdes_chunk_byte_parser_top
  import sdcbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,     // items_per_chunk
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,    // in_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ssrc[31:0], item_index[39:32], item_type[47:40], item_length[55:48],
  // value_byte[63:56], value_index[71:64], chunk_bytes[87:72], status[89:88]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser     // byte_role
);

  logic [7:0]  items_cfg_q;
  phase_e      phase_q, phase_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic [1:0]  ssrc_cnt_q, ssrc_cnt_d;
  logic [7:0]  items_left_q, items_left_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  vcnt_q, vcnt_d;
  logic [15:0] total_q, total_d;
  logic        cname_q, cname_d;
  logic [7:0]  idx_q, idx_d;

  status_e     status;
  logic        item_end;
  logic [7:0]  vbyte;
  logic [7:0]  vidx;
  logic        s_fire;
  result_t     res_d, res_q;
  logic [1:0]  role_q;
  logic        m_valid_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_d      = phase_q;
    ssrc_d       = ssrc_q;
    ssrc_cnt_d   = ssrc_cnt_q;
    items_left_d = items_left_q;
    type_d       = type_q;
    len_d        = len_q;
    vcnt_d       = vcnt_q;
    cname_d      = cname_q;
    idx_d        = idx_q;
    status       = ST_CONT;
    item_end     = 1'b0;
    vbyte        = '0;
    vidx         = '0;
    total_d      = (total_q == ByteTotalMax) ? total_q : total_q + 16'd1;

    case (phase_q)
      PH_SSRC: begin
        ssrc_d     = {ssrc_q[23:0], s_axis_tdata};
        ssrc_cnt_d = ssrc_cnt_q + 2'd1;
        if (ssrc_cnt_q == SsrcLastByte) begin
          if (items_cfg_q == 8'd0) begin
            status = ST_NOCNAME;
          end else begin
            items_left_d = items_cfg_q;
            phase_d      = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        type_d  = s_axis_tdata;
        len_d   = '0;
        cname_d = cname_q || (s_axis_tdata == SdesTypeCname);
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d  = s_axis_tdata;
        vcnt_d = '0;
        if (s_axis_tdata == 8'd0) begin
          item_end = 1'b1;
        end else begin
          phase_d = PH_VAL;
        end
      end
      default: begin
        vbyte  = s_axis_tdata;
        vidx   = vcnt_q;
        vcnt_d = vcnt_q + 8'd1;
        if (vcnt_d >= len_q) begin
          item_end = 1'b1;
        end
      end
    endcase

    if (item_end) begin
      items_left_d = items_left_q - 8'd1;
      if (items_left_q == 8'd1) begin
        status = cname_q ? ST_OK : ST_NOCNAME;
      end else begin
        idx_d   = idx_q + 8'd1;
        type_d  = '0;
        len_d   = '0;
        vcnt_d  = '0;
        phase_d = PH_TYPE;
      end
    end

    res_d.ssrc        = ssrc_d;
    res_d.item_index  = idx_d;
    res_d.item_type   = type_d;
    res_d.item_length = (phase_q == PH_SSRC) ? 8'd0 : len_d;
    res_d.value_byte  = vbyte;
    res_d.value_index = vidx;
    res_d.chunk_bytes = total_d;
    res_d.status      = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_cfg_q <= ItemsCfgReset;
    end else if (cfg_we_i) begin
      items_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SSRC;
      ssrc_q       <= '0;
      ssrc_cnt_q   <= '0;
      items_left_q <= '0;
      type_q       <= '0;
      len_q        <= '0;
      vcnt_q       <= '0;
      total_q      <= '0;
      cname_q      <= 1'b0;
      idx_q        <= '0;
    end else if (s_fire) begin
      if (status != ST_CONT) begin
        phase_q      <= PH_SSRC;
        ssrc_q       <= '0;
        ssrc_cnt_q   <= '0;
        items_left_q <= '0;
        type_q       <= '0;
        len_q        <= '0;
        vcnt_q       <= '0;
        total_q      <= '0;
        cname_q      <= 1'b0;
        idx_q        <= '0;
      end else begin
        phase_q      <= phase_d;
        ssrc_q       <= ssrc_d;
        ssrc_cnt_q   <= ssrc_cnt_d;
        items_left_q <= items_left_d;
        type_q       <= type_d;
        len_q        <= len_d;
        vcnt_q       <= vcnt_d;
        total_q      <= total_d;
        cname_q      <= cname_d;
        idx_q        <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_q  <= res_d;
      role_q <= phase_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = role_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  a_ok_not_on_ssrc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (res_q.status == ST_OK) |-> (role_q != PH_SSRC))
    else $error("chunk reported ok on an SSRC byte");

  a_ssrc_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (role_q == PH_SSRC) |-> (res_q.item_length == 8'd0))
    else $error("item length reported during SSRC bytes");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (status != ST_CONT) |=> (phase_q == PH_SSRC) && (total_q == 16'd0))
    else $error("parser did not restart after chunk end");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (res_q.chunk_bytes != 16'd0))
    else $error("result with zero chunk byte count");

endmodule
